@@ src/sorted_dedup_queue_defines.svh @@
// assertion macros for the sorted dedup queue
`ifndef SORTED_DEDUP_QUEUE_DEFINES_SVH
`define SORTED_DEDUP_QUEUE_DEFINES_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication, disabled while reset is low
`define SDQ_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sorted_dedup_queue: check failed");
// next-cycle implication, disabled while reset is low
`define SDQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sorted_dedup_queue: check failed");
`else
`define SDQ_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define SDQ_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

@@ src/sdq_pkg.sv @@
// shared constants and types of the sorted dedup queue
`default_nettype none

package sdq_pkg;

    localparam int DEPTH      = 128;
    localparam int VALUE_BITS = 16;
    localparam int COUNT_BITS = $clog2(DEPTH + 1);
    localparam int GROUP_SIZE = 16;
    localparam int NUM_GROUPS = (DEPTH + GROUP_SIZE - 1) / GROUP_SIZE;

    typedef enum logic {
        REQ_INSERT = 1'b0,
        REQ_REMOVE = 1'b1
    } t_req;

    typedef enum logic [2:0] {
        ST_INSERTED = 3'd0,
        ST_DUP      = 3'd1,
        ST_FULL     = 3'd2,
        ST_REMOVED  = 3'd3,
        ST_EMPTY    = 3'd4
    } t_status;

    // per-cycle commands broadcast to every cell
    typedef struct packed {
        logic cmp;   // register compare flags against the pending value
        logic ins;   // apply a sorted insert
        logic del;   // shift everything one cell toward the head
    } t_cell_ctl;

endpackage

`default_nettype wire

@@ src/sdq_ifs.sv @@
// valid/ready channel interfaces for request and result beats
`default_nettype none

interface sdq_in_if;
    logic        valid;
    logic        ready;
    logic        req_type;
    logic [15:0] value;

    modport source (output valid, output req_type, output value, input ready);
    modport sink   (input valid, input req_type, input value, output ready);
endinterface

interface sdq_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [15:0] data_out;
    logic        queue_empty;
    logic        queue_full;

    modport source (output valid, output status, output data_out,
                    output queue_empty, output queue_full, input ready);
    modport sink   (input valid, input status, input data_out,
                    input queue_empty, input queue_full, output ready);
endinterface

`default_nettype wire

@@ src/sorted_dedup_queue.sv @@
// top level of the sorted dedup queue: cell chain, duplicate tree and control
`default_nettype none

// Sorted dedup queue: holds up to 128 distinct 16-bit values in ascending
// order, for putting out-of-order sequence numbers back in order. An insert
// beat (req_type 0) places its value at its sorted slot; it is refused with
// status 2 when the queue is full (even for a value already held) and with
// status 1 when the value is already present. A remove beat (req_type 1)
// returns the smallest value with status 3, or status 4 and data_out 0 when
// the queue is empty. Every result beat carries the empty and full flags as
// they stand after the request. Storage is a row of identical cells; every
// cell compares its entry with the request value on its own and trades its
// entry with its neighbors, so inserts and removes move the whole row
// together. Each request passes through S_IDLE (the accept), S_CMP (the cell
// compares), S_RED (the registered OR of the per-cell match flags in groups
// of 16) and S_APPLY (combine the groups and shift the row). The result
// beat is registered when the request commits. A new request is taken as
// soon as the previous one is committed, and not before, even while its
// result beat still waits on the output register; a result that is not
// taken holds the next request in its last cycle until the output register
// frees.
// No clearing pass is needed after reset: slot occupancy follows the count.

`include "sorted_dedup_queue_defines.svh"

module sorted_dedup_queue (
    input  wire        i_clk,
    input  wire        i_rst_n,
    sdq_in_if.sink     i_in,
    sdq_out_if.source  o_out
);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_CMP   = 4'b0010,
        S_RED   = 4'b0100,
        S_APPLY = 4'b1000
    } t_state;

    localparam int PAD_BITS = sdq_pkg::NUM_GROUPS * sdq_pkg::GROUP_SIZE;

    t_state                                r_state;
    t_state                                n_state;
    sdq_pkg::t_req                         r_req;
    logic [sdq_pkg::VALUE_BITS-1:0]        r_v;
    logic [sdq_pkg::COUNT_BITS-1:0]        r_count;
    logic [sdq_pkg::COUNT_BITS-1:0]        n_count;
    logic [sdq_pkg::NUM_GROUPS-1:0]        r_grp;

    // output register
    logic                                  r_out_valid;
    sdq_pkg::t_status                      r_status;
    sdq_pkg::t_status                      n_status;
    logic [15:0]                           r_data;
    logic [15:0]                           n_data;
    logic                                  r_empty;
    logic                                  r_full;

    sdq_pkg::t_cell_ctl                    w_ctl;
    logic                                  w_commit;
    logic                                  w_dup;
    logic                                  w_is_full;
    logic                                  w_is_empty;
    logic [sdq_pkg::DEPTH-1:0]             w_occ;
    logic [sdq_pkg::VALUE_BITS-1:0]        w_val [sdq_pkg::DEPTH];
    logic [sdq_pkg::DEPTH-1:0]             w_lt;
    logic [sdq_pkg::DEPTH-1:0]             w_eq;
    logic [PAD_BITS-1:0]                   w_eq_pad;

    assign w_is_full  = (r_count == sdq_pkg::COUNT_BITS'(sdq_pkg::DEPTH));
    assign w_is_empty = (r_count == '0);

    // result leaves the apply state only when the output register is free
    assign w_commit = (r_state == S_APPLY) && (!r_out_valid || o_out.ready);

    // duplicate: any group flagged a match
    assign w_dup = |r_grp;

    assign i_in.ready = (r_state == S_IDLE);

    always_comb begin
        w_ctl.cmp = (r_state == S_CMP);
        w_ctl.ins = w_commit && (r_req == sdq_pkg::REQ_INSERT) && !w_is_full && !w_dup;
        w_ctl.del = w_commit && (r_req == sdq_pkg::REQ_REMOVE) && !w_is_empty;
    end

    // slot i holds a live entry when it lies below the count
    always_comb begin
        for (int i = 0; i < sdq_pkg::DEPTH; i++) begin
            w_occ[i] = (sdq_pkg::COUNT_BITS'(i) < r_count);
        end
    end

    // cell chain
    for (genvar g = 0; g < sdq_pkg::DEPTH; g++) begin : g_cell
        logic [sdq_pkg::VALUE_BITS-1:0] w_prev_val;
        logic                           w_prev_lt;
        logic [sdq_pkg::VALUE_BITS-1:0] w_next_val;

        if (g == 0) begin : g_head
            assign w_prev_val = '0;
            assign w_prev_lt  = 1'b1;
        end else begin : g_body
            assign w_prev_val = w_val[g-1];
            assign w_prev_lt  = w_lt[g-1];
        end

        if (g == sdq_pkg::DEPTH - 1) begin : g_tail
            assign w_next_val = w_val[g];
        end else begin : g_inner
            assign w_next_val = w_val[g+1];
        end

        sdq_cell u_cell (
            .i_clk      (i_clk),
            .i_ctl      (w_ctl),
            .i_occ      (w_occ[g]),
            .i_value    (r_v),
            .i_prev_val (w_prev_val),
            .i_prev_lt  (w_prev_lt),
            .i_next_val (w_next_val),
            .o_val      (w_val[g]),
            .o_lt       (w_lt[g]),
            .o_eq       (w_eq[g])
        );
    end

    // registered first level of the match reduction
    assign w_eq_pad = PAD_BITS'(w_eq);

    always_ff @(posedge i_clk) begin
        if (r_state == S_RED) begin
            for (int k = 0; k < sdq_pkg::NUM_GROUPS; k++) begin
                r_grp[k] <= |w_eq_pad[k*sdq_pkg::GROUP_SIZE +: sdq_pkg::GROUP_SIZE];
            end
        end
    end

    // result of the request being committed
    always_comb begin
        n_count  = r_count;
        n_data   = '0;
        n_status = sdq_pkg::ST_INSERTED;
        if (r_req == sdq_pkg::REQ_INSERT) begin
            if (w_is_full) begin
                n_status = sdq_pkg::ST_FULL;
            end else if (w_dup) begin
                n_status = sdq_pkg::ST_DUP;
            end else begin
                n_status = sdq_pkg::ST_INSERTED;
                n_count  = r_count + 1'b1;
            end
        end else begin
            if (w_is_empty) begin
                n_status = sdq_pkg::ST_EMPTY;
            end else begin
                n_status = sdq_pkg::ST_REMOVED;
                n_data   = 16'(w_val[0]);
                n_count  = r_count - 1'b1;
            end
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (i_in.valid) n_state = S_CMP;
            S_CMP:   n_state = S_RED;
            S_RED:   n_state = S_APPLY;
            S_APPLY: if (w_commit) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_commit) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // request and result payload
    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_req <= sdq_pkg::t_req'(i_in.req_type);
            r_v   <= i_in.value[sdq_pkg::VALUE_BITS-1:0];
        end
        if (w_commit) begin
            r_status <= n_status;
            r_data   <= n_data;
            r_empty  <= (n_count == '0);
            r_full   <= (n_count == sdq_pkg::COUNT_BITS'(sdq_pkg::DEPTH));
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.status      = r_status;
    assign o_out.data_out    = r_data;
    assign o_out.queue_empty = r_empty;
    assign o_out.queue_full  = r_full;

    // count stays within the row
    `SDQ_ASSERT_NOW(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= sdq_pkg::COUNT_BITS'(sdq_pkg::DEPTH))
    // count moves only when a request commits
    `SDQ_ASSERT_NEXT(a_count_hold, i_clk, i_rst_n, !w_commit, $stable(r_count))
    // a sorted insert grows the queue by exactly one entry
    `SDQ_ASSERT_NEXT(a_insert_grow, i_clk, i_rst_n, w_ctl.ins, r_count == $past(r_count) + 1'b1)
    // a commit always presents a result beat next cycle
    `SDQ_ASSERT_NEXT(a_commit_out, i_clk, i_rst_n, w_commit, r_out_valid && (r_state == S_IDLE))

endmodule

`default_nettype wire

@@ src/sdq_cell.sv @@
// one storage cell of the sorted chain
`default_nettype none

module sdq_cell (
    input  wire                              i_clk,
    input  wire  sdq_pkg::t_cell_ctl         i_ctl,
    input  wire                              i_occ,
    input  wire  [sdq_pkg::VALUE_BITS-1:0]   i_value,
    input  wire  [sdq_pkg::VALUE_BITS-1:0]   i_prev_val,
    input  wire                              i_prev_lt,
    input  wire  [sdq_pkg::VALUE_BITS-1:0]   i_next_val,
    output logic [sdq_pkg::VALUE_BITS-1:0]   o_val,
    output logic                             o_lt,
    output logic                             o_eq
);

    logic [sdq_pkg::VALUE_BITS-1:0] r_val;
    logic [sdq_pkg::VALUE_BITS-1:0] n_val;
    logic                           r_lt;
    logic                           r_eq;

    // cells below the insert point keep, the insert point takes the new value,
    // cells above it take their lower neighbor; on a remove each cell takes its upper neighbor
    always_comb begin
        n_val = r_val;
        if (i_ctl.ins && !r_lt) begin
            n_val = i_prev_lt ? i_value : i_prev_val;
        end else if (i_ctl.del) begin
            n_val = i_next_val;
        end
    end

    always_ff @(posedge i_clk) begin
        r_val <= n_val;
        if (i_ctl.cmp) begin
            r_lt <= i_occ && (r_val < i_value);
            r_eq <= i_occ && (r_val == i_value);
        end
    end

    assign o_val = r_val;
    assign o_lt  = r_lt;
    assign o_eq  = r_eq;

endmodule

`default_nettype wire
